/* rtl/ilid_pkg.sv */
// ----------------------------------------------------------------------------
// ilid_pkg
// Shared types and codes for the indexed list core: item and result
// structs, operation and status codes, controller states and commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ilid_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 5;
  localparam int CNT_W     = 5;
  localparam int MODE_W    = 3;
  localparam int STAT_W    = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ     = 3'd0,
    MODE_INS_HEAD = 3'd1,
    MODE_INS_TAIL = 3'd2,
    MODE_INS_AT   = 3'd3,
    MODE_DELETE   = 3'd4
  } mode_e;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic signed [DATA_W-1:0] NO_VALUE = -32'sd1;

  typedef struct packed {
    logic        [MODE_W-1:0] mode;
    logic        [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] item_value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic        [STAT_W-1:0] status;
    logic        [CNT_W-1:0]  count;
  } result_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctrl_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

/* rtl/ilid_ctrl.sv */
// ----------------------------------------------------------------------------
// ilid_ctrl
// Two-state sequencer: captures an item, then executes it once the result
// register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilid_ctrl
  import ilid_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_ready,
  output logic           result_valid,
  input  wire logic      result_ready,
  output ctrl_cmd_t      cmd
);

  ctrl_state_e state;
  ctrl_state_e state_next;
  logic        slot_free;

  // result register can take a new value when empty or being drained
  assign slot_free = !result_valid || result_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      S_EXEC: begin
        cmd.exec = slot_free;
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/ilid_datapath.sv */
// ----------------------------------------------------------------------------
// ilid_datapath
// Row of element cells with parallel shift, the length register, the
// operation decode and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilid_datapath
  import ilid_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  ctrl_cmd_t  cmd,
  input  item_t      item,
  output result_t    result
);

  localparam int LW   = $clog2(DEPTH + 1);
  localparam int CW   = (LW > POS_W) ? LW : POS_W;
  localparam int RD_N = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

  item_t              op;
  logic [LW-1:0]      length;
  logic [LW-1:0]      length_next;
  logic [DATA_W-1:0]  cells [DEPTH];

  logic [CW-1:0]      pos_x;
  logic [CW-1:0]      len_x;
  logic [CW-1:0]      ins_at;
  logic               full;
  logic               ins_ok;
  logic               del_ok;
  logic [DATA_W-1:0]  rd_word;
  logic [DATA_W-1:0]  rv;
  logic [STAT_W-1:0]  st;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= item;
    end
  end

  assign pos_x = CW'(op.position);
  assign len_x = CW'(length);
  assign full  = (length == LW'(DEPTH));

  // read port covers only the indexes a position can reach
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < RD_N; i++) begin
      if (op.position == POS_W'(i)) begin
        rd_word = cells[i];
      end
    end
  end

  always_comb begin
    rv     = NO_VALUE;
    st     = ST_DONE;
    ins_ok = 1'b0;
    del_ok = 1'b0;
    ins_at = '0;
    unique case (mode_e'(op.mode))
      MODE_READ: begin
        if (pos_x < len_x) begin
          rv = rd_word;
        end else begin
          st = ST_RANGE;
        end
      end
      MODE_INS_HEAD: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      MODE_INS_TAIL: begin
        ins_at = len_x;
        if (full) begin
          st = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      MODE_INS_AT: begin
        ins_at = pos_x;
        // range check wins over the full check
        if (pos_x > len_x) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      MODE_DELETE: begin
        if (pos_x >= len_x) begin
          st = ST_RANGE;
        end else begin
          del_ok = 1'b1;
        end
      end
      default: st = ST_RANGE;
    endcase
  end

  always_comb begin
    length_next = length;
    if (ins_ok) begin
      length_next = length + 1'b1;
    end else if (del_ok) begin
      length_next = length - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (cmd.exec) begin
      length <= length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result.read_value <= rv;
      result.status     <= st;
      result.count      <= CNT_W'(length_next);
    end
  end

  // each cell looks at its own index against the insert point, the delete position and the length
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam logic [CW-1:0] IDX    = CW'(g);
    localparam logic [CW-1:0] IDX_UP = CW'(g + 1);
    logic [DATA_W-1:0] below;
    logic [DATA_W-1:0] above;

    if (g == 0) begin : g_first
      assign below = op.item_value;
    end else begin : g_mid
      assign below = cells[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign above = cells[g];
    end else begin : g_inner
      assign above = cells[g+1];
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (ins_ok && IDX == ins_at) begin
          cells[g] <= op.item_value;
        end else if (ins_ok && IDX > ins_at && IDX <= len_x) begin
          cells[g] <= below;
        end else if (del_ok && IDX >= pos_x && IDX_UP < len_x) begin
          cells[g] <= above;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/indexed_list_insert_delete_core.sv */
// an item is first captured in the operand register and then executed once the result register
//   is free; the shift for any index, the length and the result are all written in that execute step
// a new item is taken only after the previous one has executed, as set by the two-state sequencer
// a waiting result holds the execute step, and the input stays not ready until it runs
// reset clears the length and the handshake state; stored values are not
//   cleared and only positions below the length are ever read
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core
// Ordered list of signed words with read, insert at head, tail or index,
// and delete at index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_insert_delete_core
  import ilid_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       result_valid,
  input  wire logic  result_ready,
  output result_t    result
);

  ctrl_cmd_t cmd;

  ilid_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  ilid_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .result (result)
  );

endmodule

`default_nettype wire

/* rtl/ilid_checker.sv */
// ----------------------------------------------------------------------------
// ilid_checker
// Port-level checks on the indexed list core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilid_checker
  import ilid_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic item_valid,
  input wire logic item_ready,
  input wire logic result_valid,
  input wire logic result_ready,
  input result_t   result
);

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // one item at a time: no transfer right after a transfer
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("item taken while previous one in flight");

  // a failed operation reports no value
  a_fail_no_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != ST_DONE |-> result.read_value == NO_VALUE)
    else $error("failed operation returned a value");

  a_status_count: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.status == ST_DONE || result.status == ST_RANGE ||
                      result.status == ST_FULL) &&
                     (DEPTH >= 32 || int'(result.count) <= DEPTH))
    else $error("bad status or count");

endmodule

bind indexed_list_insert_delete_core ilid_checker #(.DEPTH(DEPTH)) u_ilid_checker (.*);

`default_nettype wire
